/* rtl/oec_pkg.sv */
package oec_pkg;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_BACKUP  = 3'd1;
    localparam logic [2:0] MODE_ROTATE  = 3'd2;
    localparam logic [2:0] MODE_PUSH    = 3'd3;
    localparam logic [2:0] MODE_TRAPPED = 3'd4;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_FWD   = 3'd2;
    localparam logic [2:0] CMD_BACK  = 3'd3;
    localparam logic [2:0] CMD_RIGHT = 3'd4;
    localparam logic [2:0] CMD_LEFT  = 3'd5;

    localparam logic [2:0] OBS_FRONT   = 3'd1;
    localparam logic [2:0] OBS_REAR    = 3'd2;
    localparam logic [2:0] OBS_LEFT    = 3'd3;
    localparam logic [2:0] OBS_RIGHT   = 3'd4;
    localparam logic [2:0] OBS_SIDES   = 3'd5;
    localparam logic [2:0] OBS_TRAPPED = 3'd6;

    localparam logic [2:0] CFG_DRIVE_SPEED    = 3'd0;
    localparam logic [2:0] CFG_TURN_SPEED_MAX = 3'd1;
    localparam logic [2:0] CFG_BACKUP_TO      = 3'd2;
    localparam logic [2:0] CFG_ROT_TO_IMU     = 3'd3;
    localparam logic [2:0] CFG_ROT_TO_NOIMU   = 3'd4;
    localparam logic [2:0] CFG_PUSH_TIME      = 3'd5;
    localparam logic [2:0] CFG_TRAPPED_WAIT   = 3'd6;

    localparam logic signed [13:0] ANGLE_HALF = 14'sd1800;
    localparam logic signed [13:0] ANGLE_FULL = 14'sd3600;
    localparam logic [10:0] TURN_SPEED_MIN = 11'd140;
    localparam logic [12:0] TURN_DONE_ERR  = 13'd60;
    localparam logic [11:0] TRAP_OFFSET_MIN = 12'd250;
    localparam logic [11:0] FRONT_OFFSET_MIN = 12'd300;
    localparam logic signed [11:0] SIDE_LIMIT  = 12'sd300;
    localparam logic signed [11:0] SIDE_TURN   = 12'sd600;
    localparam logic signed [11:0] FRONT_TURN  = 12'sd750;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [2:0]         obstacle_status;
        logic               front_blocked_thr;
        logic               front_blocked_crit;
        logic               rear_blocked_crit;
        logic               still_trapped;
        logic signed [11:0] clearance_offset;
        logic signed [11:0] yaw_now;
        logic               imu_present;
        logic               side_one_farther;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         motor_cmd;
        logic [7:0]         motor_speed;
        logic [2:0]         motion_state;
        logic signed [11:0] target_heading;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  drive_speed;
        logic [7:0]  turn_speed_max;
        logic [15:0] backup_timeout_ms;
        logic [15:0] rotate_timeout_imu_ms;
        logic [15:0] rotate_timeout_noimu_ms;
        logic [15:0] push_time_ms;
        logic [15:0] trapped_wait_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [11:0] goal_yaw;
        logic [31:0]        entry_time;
    } t_state;

    function automatic logic signed [13:0] wrap_angle(input logic signed [13:0] a);
        logic signed [13:0] r;
        r = a;
        if (r > ANGLE_HALF) r = r - ANGLE_FULL;
        if (r < -ANGLE_HALF) r = r + ANGLE_FULL;
        return r;
    endfunction

endpackage

/* rtl/oec_if.sv */
interface oec_in_if;
    logic                 valid;
    logic                 ready;
    oec_pkg::t_in_item    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface oec_out_if;
    logic                 valid;
    logic                 ready;
    oec_pkg::t_out_item   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface oec_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/oec_step.sv */
module oec_step (
    input  oec_pkg::t_in_item  i_item,
    input  oec_pkg::t_state    i_state,
    input  oec_pkg::t_cfg      i_cfg,
    output oec_pkg::t_out_item o_result,
    output oec_pkg::t_state    o_state
);

    logic [31:0]        elapsed;
    logic signed [11:0] offset;
    logic [11:0]        off_mag;
    logic signed [13:0] aim_yaw;
    logic signed [13:0] err;
    logic [12:0]        err_mag;
    logic [10:0]        spd_raw;
    logic [7:0]         turn_spd;
    logic               turn_done;
    logic               aim;
    logic [2:0]         cmd;
    logic [7:0]         speed;
    logic [2:0]         n_mode;
    logic [31:0]        n_entry;

    assign elapsed = i_item.now_ms - i_state.entry_time;
    assign off_mag = i_item.clearance_offset[11] ? 12'(-i_item.clearance_offset)
                                                 : 12'(i_item.clearance_offset);

    assign err = oec_pkg::wrap_angle(14'(i_state.goal_yaw) - 14'(i_item.yaw_now));
    assign err_mag = err[13] ? 13'(-err) : 13'(err);
    assign spd_raw = oec_pkg::TURN_SPEED_MIN + 11'(err_mag[12:2]);
    assign turn_spd = (spd_raw > {3'b000, i_cfg.turn_speed_max}) ? i_cfg.turn_speed_max
                                                                 : spd_raw[7:0];
    assign turn_done = i_item.imu_present
        ? ((err_mag < oec_pkg::TURN_DONE_ERR)
           || (elapsed > {16'h0000, i_cfg.rotate_timeout_imu_ms}))
        : (elapsed > {16'h0000, i_cfg.rotate_timeout_noimu_ms});

    always_comb begin
        cmd     = oec_pkg::CMD_NONE;
        speed   = 8'd0;
        aim     = 1'b0;
        offset  = i_item.clearance_offset;
        n_mode  = i_state.mode;
        n_entry = i_state.entry_time;
        unique case (i_state.mode)
            oec_pkg::MODE_BACKUP: begin
                if (!i_item.front_blocked_thr) begin
                    cmd    = oec_pkg::CMD_STOP;
                    n_mode = oec_pkg::MODE_IDLE;
                end else if (i_item.rear_blocked_crit
                             || (elapsed > {16'h0000, i_cfg.backup_timeout_ms})) begin
                    aim = 1'b1;
                end else begin
                    cmd   = oec_pkg::CMD_BACK;
                    speed = i_cfg.drive_speed;
                end
            end
            oec_pkg::MODE_ROTATE: begin
                if (turn_done) begin
                    cmd     = oec_pkg::CMD_STOP;
                    n_mode  = oec_pkg::MODE_PUSH;
                    n_entry = i_item.now_ms;
                end else begin
                    speed = turn_spd;
                    cmd   = (err > 14'sd0) ? oec_pkg::CMD_RIGHT : oec_pkg::CMD_LEFT;
                end
            end
            oec_pkg::MODE_PUSH: begin
                if (i_item.front_blocked_crit
                    || (elapsed > {16'h0000, i_cfg.push_time_ms})) begin
                    cmd    = oec_pkg::CMD_STOP;
                    n_mode = oec_pkg::MODE_IDLE;
                end else begin
                    cmd   = oec_pkg::CMD_FWD;
                    speed = i_cfg.drive_speed;
                end
            end
            oec_pkg::MODE_TRAPPED: begin
                cmd = oec_pkg::CMD_STOP;
                if (!i_item.still_trapped) begin
                    n_mode = oec_pkg::MODE_IDLE;
                end else if ((off_mag > oec_pkg::TRAP_OFFSET_MIN)
                             && (elapsed > {16'h0000, i_cfg.trapped_wait_ms})) begin
                    aim = 1'b1;
                end
            end
            default: begin
                unique case (i_item.obstacle_status)
                    oec_pkg::OBS_TRAPPED: begin
                        n_mode  = oec_pkg::MODE_TRAPPED;
                        n_entry = i_item.now_ms;
                        cmd     = oec_pkg::CMD_STOP;
                    end
                    oec_pkg::OBS_REAR: begin
                        if (!i_item.front_blocked_thr) begin
                            n_mode  = oec_pkg::MODE_PUSH;
                            n_entry = i_item.now_ms;
                            cmd     = oec_pkg::CMD_FWD;
                            speed   = i_cfg.drive_speed;
                        end else begin
                            aim = 1'b1;
                        end
                    end
                    oec_pkg::OBS_LEFT: begin
                        if (i_item.clearance_offset < oec_pkg::SIDE_LIMIT) begin
                            offset = oec_pkg::SIDE_TURN;
                        end
                        aim = 1'b1;
                    end
                    oec_pkg::OBS_RIGHT: begin
                        if (i_item.clearance_offset > -oec_pkg::SIDE_LIMIT) begin
                            offset = -oec_pkg::SIDE_TURN;
                        end
                        aim = 1'b1;
                    end
                    oec_pkg::OBS_SIDES: begin
                        aim = 1'b1;
                    end
                    oec_pkg::OBS_FRONT: begin
                        if (off_mag < oec_pkg::FRONT_OFFSET_MIN) begin
                            offset = i_item.side_one_farther ? oec_pkg::FRONT_TURN
                                                             : -oec_pkg::FRONT_TURN;
                        end
                        aim = 1'b1;
                    end
                    default: begin
                        n_mode = oec_pkg::MODE_IDLE;
                        cmd    = oec_pkg::CMD_STOP;
                    end
                endcase
            end
        endcase
    end

    assign aim_yaw = oec_pkg::wrap_angle(14'(i_item.yaw_now) + 14'(offset));

    always_comb begin
        o_state.mode       = aim ? oec_pkg::MODE_ROTATE : n_mode;
        o_state.goal_yaw   = aim ? aim_yaw[11:0] : i_state.goal_yaw;
        o_state.entry_time = aim ? i_item.now_ms : n_entry;
    end

    assign o_result.motor_cmd      = cmd;
    assign o_result.motor_speed    = speed;
    assign o_result.motion_state   = o_state.mode;
    assign o_result.target_heading = o_state.goal_yaw;

endmodule

/* rtl/obstacle_evasion_controller_top.sv */
// Obstacle evasion controller. One control tick per transfer on i_in gives exactly one
// result on o_out. A tick is captured in an input register and its result moves into the
// output register once that register is empty or being drained, which raises o_out.valid;
// a new tick is taken every cycle while o_out keeps draining. A single pass of next-state
// logic lies between the two registers. The configuration port is always ready and its
// writes are meant for when no tick is in flight.
module obstacle_evasion_controller_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    oec_in_if.sink           i_in,
    oec_out_if.source        o_out,
    oec_cfg_if.sink          i_cfg
);

    oec_pkg::t_cfg      r_cfg;
    oec_pkg::t_state    r_state;
    oec_pkg::t_state    n_state;
    oec_pkg::t_in_item  r_in;
    logic               r_in_valid;
    oec_pkg::t_out_item r_out;
    oec_pkg::t_out_item n_out;
    logic               r_out_valid;
    logic               adv;

    assign adv         = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    oec_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_result (n_out),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_speed             <= 8'd180;
            r_cfg.turn_speed_max          <= 8'd200;
            r_cfg.backup_timeout_ms       <= 16'd3500;
            r_cfg.rotate_timeout_imu_ms   <= 16'd2000;
            r_cfg.rotate_timeout_noimu_ms <= 16'd500;
            r_cfg.push_time_ms            <= 16'd1000;
            r_cfg.trapped_wait_ms         <= 16'd1500;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                oec_pkg::CFG_DRIVE_SPEED:    r_cfg.drive_speed <= i_cfg.wdata[7:0];
                oec_pkg::CFG_TURN_SPEED_MAX: r_cfg.turn_speed_max <= i_cfg.wdata[7:0];
                oec_pkg::CFG_BACKUP_TO:      r_cfg.backup_timeout_ms <= i_cfg.wdata;
                oec_pkg::CFG_ROT_TO_IMU:     r_cfg.rotate_timeout_imu_ms <= i_cfg.wdata;
                oec_pkg::CFG_ROT_TO_NOIMU:   r_cfg.rotate_timeout_noimu_ms <= i_cfg.wdata;
                oec_pkg::CFG_PUSH_TIME:      r_cfg.push_time_ms <= i_cfg.wdata;
                oec_pkg::CFG_TRAPPED_WAIT:   r_cfg.trapped_wait_ms <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OBS_CLEAR   = 3'd0;
    localparam logic [2:0] OBS_UNKNOWN = 3'd7;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;

    localparam int TURN_FLOOR    = 140;
    localparam int TURN_CLOSE    = 60;
    localparam int TRAP_MIN_OFS  = 250;
    localparam int FRONT_MIN_OFS = 300;
    localparam int SIDE_MIN_OFS  = 300;
    localparam int SIDE_FORCED   = 600;
    localparam int FRONT_FORCED  = 750;
    localparam int HALF_TURN     = 1800;
    localparam int FULL_TURN     = 3600;

    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 232;
    localparam int CALM_FROM       = 700;
    localparam int CALM_TO         = 1000;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 200;

    localparam oec_pkg::t_out_item HALT_IDLE =
        '{oec_pkg::CMD_STOP, 8'd0, oec_pkg::MODE_IDLE, 12'sd0};
    localparam oec_pkg::t_out_item PUSH_FWD =
        '{oec_pkg::CMD_FWD, 8'd180, oec_pkg::MODE_PUSH, 12'sd0};
    localparam oec_pkg::t_out_item AIM_LEFT =
        '{oec_pkg::CMD_NONE, 8'd0, oec_pkg::MODE_ROTATE, -12'sd1500};

    logic i_clk;
    logic i_rst_n;

    oec_in_if  tick_if ();
    oec_out_if cmd_if ();
    oec_cfg_if reg_if ();

    obstacle_evasion_controller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (cmd_if),
        .i_cfg   (reg_if)
    );

    oec_pkg::t_cfg      limits;
    oec_pkg::t_state    ctl;
    oec_pkg::t_out_item cmd_q [$];
    oec_pkg::t_in_item  plan_tick [$];
    bit                 plan_known [$];
    oec_pkg::t_out_item plan_want [$];
    int                 errors = 0;
    int                 sent = 0;
    int                 taken = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int fold_angle(input int a);
        int r;
        r = a;
        if (r > HALF_TURN) r = r - FULL_TURN;
        if (r < -HALF_TURN) r = r + FULL_TURN;
        return r;
    endfunction

    // next controller output for one tick, advances the shadow state
    function automatic oec_pkg::t_out_item tick_outcome(input oec_pkg::t_in_item t);
        oec_pkg::t_out_item r;
        logic [31:0]        since;
        logic [2:0]         cmd;
        int                 ofs;
        int                 yaw;
        int                 err;
        int                 mag;
        int                 spd;
        bit                 aim;
        ofs = $signed(t.clearance_offset);
        yaw = $signed(t.yaw_now);
        since = t.now_ms - ctl.entry_time;
        cmd = oec_pkg::CMD_NONE;
        spd = 0;
        aim = 1'b0;
        case (ctl.mode)
            oec_pkg::MODE_BACKUP: begin
                if (!t.front_blocked_thr) begin
                    cmd = oec_pkg::CMD_STOP;
                    ctl.mode = oec_pkg::MODE_IDLE;
                end else if (t.rear_blocked_crit || since > limits.backup_timeout_ms) begin
                    aim = 1'b1;
                end else begin
                    cmd = oec_pkg::CMD_BACK;
                    spd = int'(limits.drive_speed);
                end
            end
            oec_pkg::MODE_ROTATE: begin
                err = fold_angle($signed(ctl.goal_yaw) - yaw);
                mag = (err < 0) ? -err : err;
                if (t.imu_present ? (mag < TURN_CLOSE || since > limits.rotate_timeout_imu_ms)
                                  : (since > limits.rotate_timeout_noimu_ms)) begin
                    cmd = oec_pkg::CMD_STOP;
                    ctl.mode = oec_pkg::MODE_PUSH;
                    ctl.entry_time = t.now_ms;
                end else begin
                    spd = TURN_FLOOR + mag / 4;
                    if (spd > int'(limits.turn_speed_max)) spd = int'(limits.turn_speed_max);
                    cmd = (err > 0) ? oec_pkg::CMD_RIGHT : oec_pkg::CMD_LEFT;
                end
            end
            oec_pkg::MODE_PUSH: begin
                if (t.front_blocked_crit || since > limits.push_time_ms) begin
                    cmd = oec_pkg::CMD_STOP;
                    ctl.mode = oec_pkg::MODE_IDLE;
                end else begin
                    cmd = oec_pkg::CMD_FWD;
                    spd = int'(limits.drive_speed);
                end
            end
            oec_pkg::MODE_TRAPPED: begin
                cmd = oec_pkg::CMD_STOP;
                if (!t.still_trapped) begin
                    ctl.mode = oec_pkg::MODE_IDLE;
                end else if (((ofs < 0) ? -ofs : ofs) > TRAP_MIN_OFS
                             && since > limits.trapped_wait_ms) begin
                    aim = 1'b1;
                end
            end
            default: begin
                case (t.obstacle_status)
                    oec_pkg::OBS_TRAPPED: begin
                        ctl.mode = oec_pkg::MODE_TRAPPED;
                        ctl.entry_time = t.now_ms;
                        cmd = oec_pkg::CMD_STOP;
                    end
                    oec_pkg::OBS_REAR: begin
                        if (!t.front_blocked_thr) begin
                            ctl.mode = oec_pkg::MODE_PUSH;
                            ctl.entry_time = t.now_ms;
                            cmd = oec_pkg::CMD_FWD;
                            spd = int'(limits.drive_speed);
                        end else begin
                            aim = 1'b1;
                        end
                    end
                    oec_pkg::OBS_LEFT: begin
                        if (ofs < SIDE_MIN_OFS) ofs = SIDE_FORCED;
                        aim = 1'b1;
                    end
                    oec_pkg::OBS_RIGHT: begin
                        if (ofs > -SIDE_MIN_OFS) ofs = -SIDE_FORCED;
                        aim = 1'b1;
                    end
                    oec_pkg::OBS_SIDES: begin
                        aim = 1'b1;
                    end
                    oec_pkg::OBS_FRONT: begin
                        if (((ofs < 0) ? -ofs : ofs) < FRONT_MIN_OFS)
                            ofs = t.side_one_farther ? FRONT_FORCED : -FRONT_FORCED;
                        aim = 1'b1;
                    end
                    default: begin
                        ctl.mode = oec_pkg::MODE_IDLE;
                        cmd = oec_pkg::CMD_STOP;
                    end
                endcase
            end
        endcase
        if (aim) begin
            ctl.goal_yaw = 12'(fold_angle(yaw + ofs));
            ctl.mode = oec_pkg::MODE_ROTATE;
            ctl.entry_time = t.now_ms;
        end
        r.motor_cmd = cmd;
        r.motor_speed = spd[7:0];
        r.motion_state = ctl.mode;
        r.target_heading = ctl.goal_yaw;
        return r;
    endfunction

    function automatic oec_pkg::t_in_item mk(input logic [31:0] now, input logic [2:0] status,
                                             input bit thr, input bit crit, input bit rear,
                                             input bit trap, input int ofs, input int yaw,
                                             input bit imu, input bit side);
        oec_pkg::t_in_item t;
        t.now_ms = now;
        t.obstacle_status = status;
        t.front_blocked_thr = thr;
        t.front_blocked_crit = crit;
        t.rear_blocked_crit = rear;
        t.still_trapped = trap;
        t.clearance_offset = 12'(ofs);
        t.yaw_now = 12'(yaw);
        t.imu_present = imu;
        t.side_one_farther = side;
        return t;
    endfunction

    task automatic add_row(input oec_pkg::t_in_item t, input bit known,
                           input oec_pkg::t_out_item want);
        plan_tick.push_back(t);
        plan_known.push_back(known);
        plan_want.push_back(want);
    endtask

    task automatic send_tick(input oec_pkg::t_in_item t, input bit known,
                             input oec_pkg::t_out_item want);
        oec_pkg::t_out_item calc;
        while ((sent < CALM_FROM || sent >= CALM_TO) && $urandom_range(99) < 36) begin
            tick_if.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid = 1'b1;
        tick_if.data = t;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        calc = tick_outcome(t);
        cmd_q.push_back(known ? want : calc);
        sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        reg_if.valid = 1'b1;
        reg_if.index = idx;
        reg_if.wdata = val;
        @(posedge i_clk);
        while (!reg_if.ready) @(posedge i_clk);
        case (idx)
            oec_pkg::CFG_DRIVE_SPEED:    limits.drive_speed = val[7:0];
            oec_pkg::CFG_TURN_SPEED_MAX: limits.turn_speed_max = val[7:0];
            oec_pkg::CFG_BACKUP_TO:      limits.backup_timeout_ms = val;
            oec_pkg::CFG_ROT_TO_IMU:     limits.rotate_timeout_imu_ms = val;
            oec_pkg::CFG_ROT_TO_NOIMU:   limits.rotate_timeout_noimu_ms = val;
            oec_pkg::CFG_PUSH_TIME:      limits.push_time_ms = val;
            oec_pkg::CFG_TRAPPED_WAIT:   limits.trapped_wait_ms = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle;
        tick_if.valid = 1'b0;
        while (cmd_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // output side: random back-pressure, one long hold-off, a calm stretch
    initial begin : drain_side
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        cmd_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && taken >= HOLD_AT) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                cmd_if.ready = 1'b0;
            end else if (taken >= CALM_FROM && taken < CALM_TO) begin
                cmd_if.ready = 1'b1;
            end else begin
                cmd_if.ready = ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge i_clk) begin : check_cmd
        oec_pkg::t_out_item want;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            taken++;
            if (cmd_q.size() == 0) begin
                $display("%0t: result with no tick pending: cmd %0d speed %0d state %0d head %0d",
                         $time, cmd_if.data.motor_cmd, cmd_if.data.motor_speed,
                         cmd_if.data.motion_state, $signed(cmd_if.data.target_heading));
                errors++;
            end else begin
                want = cmd_q.pop_front();
                if (cmd_if.data !== want) begin
                    $display("%0t: mismatch cmd %0d/%0d speed %0d/%0d state %0d/%0d head %0d/%0d",
                             $time, want.motor_cmd, cmd_if.data.motor_cmd,
                             want.motor_speed, cmd_if.data.motor_speed,
                             want.motion_state, cmd_if.data.motion_state,
                             $signed(want.target_heading),
                             $signed(cmd_if.data.target_heading));
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        oec_pkg::t_in_item it;
        logic [31:0]       clock_ms;
        logic [7:0]        evs;
        logic [7:0]        tsm;
        logic [15:0]       t_back;
        logic [15:0]       t_imu;
        logic [15:0]       t_noimu;
        logic [15:0]       t_push;
        logic [15:0]       t_trap;
        int                ofs;
        int                yaw;
        int                pick;
        int                span;

        i_rst_n = 1'b0;
        tick_if.valid = 1'b0;
        tick_if.data = '0;
        reg_if.valid = 1'b0;
        reg_if.index = oec_pkg::CFG_DRIVE_SPEED;
        reg_if.wdata = '0;
        limits = '{8'd180, 8'd200, 16'd3500, 16'd2000, 16'd500, 16'd1000, 16'd1500};
        ctl = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk through the idle, push, rotate and trapped states, with boundary timeouts and wraps
        add_row(mk(0, OBS_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, HALT_IDLE);
        add_row(mk(1, OBS_UNKNOWN, 1, 1, 1, 1, 2047, -2048, 1, 1), 1, HALT_IDLE);
        add_row(mk(10, oec_pkg::OBS_REAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, PUSH_FWD);
        add_row(mk(1010, OBS_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, PUSH_FWD);
        add_row(mk(1011, OBS_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, HALT_IDLE);
        add_row(mk(1100, oec_pkg::OBS_LEFT, 0, 0, 0, 0, 100, 1500, 0, 0), 1, AIM_LEFT);
        add_row(mk(1101, OBS_CLEAR, 0, 0, 0, 0, 0, 1500, 1, 0), 0, HALT_IDLE);
        add_row(mk(1102, OBS_CLEAR, 0, 0, 0, 0, 0, -1480, 1, 0), 0, HALT_IDLE);
        add_row(mk(1103, OBS_CLEAR, 0, 1, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2000, oec_pkg::OBS_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2500, OBS_CLEAR, 0, 0, 0, 0, 0, -600, 0, 0), 0, HALT_IDLE);
        add_row(mk(2501, OBS_CLEAR, 0, 0, 0, 0, 0, -600, 0, 0), 0, HALT_IDLE);
        add_row(mk(2502, OBS_CLEAR, 0, 1, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(3000, oec_pkg::OBS_FRONT, 0, 0, 0, 0, 100, -1800, 0, 1), 0, HALT_IDLE);
        add_row(mk(5001, OBS_CLEAR, 0, 0, 0, 0, 0, 2047, 1, 0), 0, HALT_IDLE);
        add_row(mk(32'hFFFF_FFFF, OBS_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(32'hFFFF_FFFF, oec_pkg::OBS_FRONT, 0, 0, 0, 0, -100, -2048, 0, 0),
                0, HALT_IDLE);
        add_row(mk(5, OBS_CLEAR, 0, 0, 0, 0, 0, 802, 1, 0), 0, HALT_IDLE);
        add_row(mk(6, OBS_CLEAR, 0, 1, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(7, oec_pkg::OBS_SIDES, 0, 0, 0, 0, 2047, 2047, 0, 0), 0, HALT_IDLE);
        add_row(mk(600, OBS_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(601, OBS_CLEAR, 0, 1, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(700, oec_pkg::OBS_TRAPPED, 0, 0, 0, 1, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2201, OBS_CLEAR, 0, 0, 0, 1, 250, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2202, OBS_CLEAR, 0, 0, 0, 1, -251, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2300, OBS_CLEAR, 0, 0, 0, 0, 0, -251, 1, 0), 0, HALT_IDLE);
        add_row(mk(2301, oec_pkg::OBS_TRAPPED, 0, 1, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2400, oec_pkg::OBS_TRAPPED, 0, 0, 0, 1, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2401, OBS_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, HALT_IDLE);
        add_row(mk(2500, oec_pkg::OBS_REAR, 1, 0, 0, 0, -2048, -2048, 0, 0), 0, HALT_IDLE);
        @(negedge i_clk);
        for (int k = 0; k < plan_tick.size(); k++)
            send_tick(plan_tick[k], plan_known[k], plan_want[k]);

        clock_ms = 32'd2600;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle;
            if (ph == 0) begin
                evs = 8'd0;
                tsm = 8'd0;
                {t_back, t_imu, t_noimu, t_push, t_trap} = '0;
                span = 3;
            end else if (ph == 1) begin
                evs = 8'hFF;
                tsm = 8'hFF;
                {t_back, t_imu, t_noimu, t_push, t_trap} = '1;
                span = 2000;
            end else begin
                evs = 8'($urandom_range(255));
                tsm = (ph == 2) ? 8'($urandom_range(TURN_FLOOR - 1))
                                : 8'($urandom_range(TURN_FLOOR, 255));
                t_back = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
                t_imu = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
                t_noimu = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
                t_push = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
                t_trap = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
                span = $urandom_range(1, 120);
            end
            if (ph == 3) clock_ms = 32'hFFFF_F000;
            write_reg(oec_pkg::CFG_DRIVE_SPEED, {8'd0, evs});
            write_reg(oec_pkg::CFG_TURN_SPEED_MAX, {8'd0, tsm});
            write_reg(oec_pkg::CFG_BACKUP_TO, t_back);
            write_reg(oec_pkg::CFG_ROT_TO_IMU, t_imu);
            write_reg(oec_pkg::CFG_ROT_TO_NOIMU, t_noimu);
            write_reg(oec_pkg::CFG_PUSH_TIME, t_push);
            write_reg(oec_pkg::CFG_TRAPPED_WAIT, t_trap);
            write_reg(CFG_UNUSED, 16'($urandom));
            reg_if.valid = 1'b0;

            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 85) clock_ms = clock_ms + $urandom_range(span);
                else if (pick < 95) clock_ms = clock_ms + $urandom_range(70000);
                else clock_ms = $urandom();

                pick = $urandom_range(99);
                if (pick < 40) begin
                    ofs = int'($urandom_range(2 * HALF_TURN)) - HALF_TURN;
                end else if (pick < 60) begin
                    ofs = ($urandom_range(1) ? TRAP_MIN_OFS : FRONT_MIN_OFS)
                          + int'($urandom_range(2)) - 1;
                    if ($urandom_range(1)) ofs = -ofs;
                end else if (pick < 75) begin
                    ofs = int'($urandom_range(2 * FRONT_MIN_OFS)) - FRONT_MIN_OFS;
                end else begin
                    ofs = int'($urandom_range(4095)) - 2048;
                end

                // near the goal while turning, so the heading test can finish the turn
                if (ctl.mode == oec_pkg::MODE_ROTATE && $urandom_range(1) == 1)
                    yaw = $signed(ctl.goal_yaw) + int'($urandom_range(2 * 80)) - 80;
                else if ($urandom_range(9) < 7)
                    yaw = int'($urandom_range(2 * HALF_TURN)) - HALF_TURN;
                else
                    yaw = int'($urandom_range(4095)) - 2048;

                pick = $urandom_range(19);
                if (pick == 0) it.obstacle_status = OBS_UNKNOWN;
                else if (pick < 3) it.obstacle_status = OBS_CLEAR;
                else it.obstacle_status = 3'($urandom_range(oec_pkg::OBS_FRONT,
                                                            oec_pkg::OBS_TRAPPED));

                it.now_ms = clock_ms;
                it.front_blocked_thr = ($urandom_range(1) == 1);
                it.front_blocked_crit = ($urandom_range(4) == 0);
                it.rear_blocked_crit = ($urandom_range(1) == 1);
                it.still_trapped = ($urandom_range(3) != 0);
                it.clearance_offset = 12'(ofs);
                it.yaw_now = 12'(yaw);
                it.imu_present = ($urandom_range(4) < 3);
                it.side_one_farther = ($urandom_range(1) == 1);
                send_tick(it, 1'b0, HALT_IDLE);
            end
        end

        settle;
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* obstacle_evasion_controller_top.f */
rtl/oec_pkg.sv
rtl/oec_if.sv
rtl/oec_step.sv
rtl/obstacle_evasion_controller_top.sv
tb/sv/testbench.sv
